FILE: src/hspc_pkg.sv
// Shared types and codes for the hard-sphere placement checker.
// No dependencies; used by every module of the block.
`default_nettype none
package hspc_pkg;

    localparam int IN_COORD_W  = 20;
    localparam int BOX_W       = 20;
    localparam int THR_W       = 40;
    localparam int TRIES_W     = 32;
    localparam int TARGET_W    = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 40;
    localparam int SLOT_W      = 10;
    localparam int TOTAL_W     = 11;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAD_THR_SQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLV_THR_SQ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRIES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 3'd4;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PROPOSE = 1'b1;

    typedef enum logic [2:0] {
        ST_BEAD_STORED    = 3'd0,
        ST_REJECTED       = 3'd1,
        ST_ACCEPTED       = 3'd2,
        ST_TRIES_EXCEEDED = 3'd3,
        ST_COMPLETE       = 3'd4,
        ST_BEAD_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        TAG_CAND,
        TAG_BEAD,
        TAG_SOLV
    } tag_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                  opcode;
        logic [IN_COORD_W-1:0] coord_x;
        logic [IN_COORD_W-1:0] coord_y;
        logic [IN_COORD_W-1:0] coord_z;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [SLOT_W-1:0]  slot_index;
        logic [TOTAL_W-1:0] placed_total;
        logic               all_placed;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic    capture;
        logic    scan_start;
        logic    scan_issue;
        logic    emit;
        status_t res;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_load;
        logic bead_full;
        logic err_latched;
        logic complete;
        logic tries_hit;
        logic issue_done;
        logic pipe_empty;
        logic overlap;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

FILE: src/hard_sphere_placement_checker_top.sv
// Top level of the hard-sphere placement checker.
// Depends on hspc_pkg, hspc_ctrl and hspc_dpath.
//
// Places solvent particles in a periodic cubic box by rejection. A load
// request (opcode 0) appends a bead position; a candidate request (opcode 1)
// is tested against all stored beads and placed particles using minimum
// image distances, and stored when nothing is closer than the squared
// bead or solvent threshold. Each request returns exactly one result.
// Timing: one request is processed at a time. Loads and candidates settled
// without testing go from acceptance through the decide step back to idle.
// A tested candidate walks the stores at one entry per cycle through a
// pipelined distance unit whose depth is set by the one-bit-per-stage
// modulo reduction against the box length. A result that cannot leave the
// output register holds the next request in its final step. A finished
// result waits in the output register while the next request is accepted.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user
// must write it only while idle, since the block does not enforce this.
`default_nettype none
module hard_sphere_placement_checker_top #(
    parameter int MAX_BEADS   = 256,
    parameter int MAX_SOLVENT = 1024,
    parameter int COORD_BITS  = 20
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [hspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hspc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire hspc_pkg::in_t                   s_data,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output hspc_pkg::out_t                       m_data
);

    hspc_pkg::cmd_t  cmd;
    hspc_pkg::stat_t stat;

    // sequencing: decide, scan, drain, finish
    hspc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat_i  (stat),
        .cmd_o   (cmd)
    );

    // stores, counters, distance pipeline and result register
    hspc_dpath #(
        .MAX_BEADS   (MAX_BEADS),
        .MAX_SOLVENT (MAX_SOLVENT),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd_i     (cmd),
        .stat_o    (stat)
    );

endmodule
`default_nettype wire

FILE: src/hspc_ctrl.sv
// Sequencing state machine of the placement checker.
// Depends on hspc_pkg; drives hspc_dpath through cmd_t, reads stat_t.
`default_nettype none
module hspc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire hspc_pkg::stat_t stat_i,
    output hspc_pkg::cmd_t      cmd_o
);

    hspc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hspc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        s_ready          = 1'b0;
        cmd_o            = '0;
        cmd_o.res        = hspc_pkg::ST_BEAD_STORED;
        unique case (state_reg)
            hspc_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.capture = 1'b1;
                    state_next    = hspc_pkg::S_DECIDE;
                end
            end
            hspc_pkg::S_DECIDE: begin
                // priority: load, latched error, complete, try limit, test
                if (stat_i.is_load) begin
                    cmd_o.res = stat_i.bead_full ? hspc_pkg::ST_BEAD_FULL
                                                 : hspc_pkg::ST_BEAD_STORED;
                end else if (stat_i.err_latched) begin
                    cmd_o.res = hspc_pkg::ST_TRIES_EXCEEDED;
                end else if (stat_i.complete) begin
                    cmd_o.res = hspc_pkg::ST_COMPLETE;
                end else if (stat_i.tries_hit) begin
                    cmd_o.res = hspc_pkg::ST_TRIES_EXCEEDED;
                end
                if (!stat_i.is_load && !stat_i.err_latched && !stat_i.complete &&
                    !stat_i.tries_hit) begin
                    cmd_o.scan_start = 1'b1;
                    state_next       = hspc_pkg::S_SCAN;
                end else if (stat_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    state_next = hspc_pkg::S_IDLE;
                end
            end
            hspc_pkg::S_SCAN: begin
                if (stat_i.issue_done) begin
                    state_next = hspc_pkg::S_DRAIN;
                end else begin
                    cmd_o.scan_issue = 1'b1;
                end
            end
            hspc_pkg::S_DRAIN: begin
                if (stat_i.pipe_empty) begin
                    state_next = hspc_pkg::S_FINISH;
                end
            end
            hspc_pkg::S_FINISH: begin
                cmd_o.res = stat_i.overlap ? hspc_pkg::ST_REJECTED
                                           : hspc_pkg::ST_ACCEPTED;
                if (stat_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    state_next = hspc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = hspc_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/hspc_dpath.sv
// Datapath: configuration, position stores, counters, distance pipeline,
// result register. Depends on hspc_pkg; commanded by hspc_ctrl.
`default_nettype none
module hspc_dpath #(
    parameter int MAX_BEADS   = 256,
    parameter int MAX_SOLVENT = 1024,
    parameter int COORD_BITS  = 20
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [hspc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [hspc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire hspc_pkg::in_t                         s_data,
    input  wire logic                                  m_ready,
    output logic                                       m_valid,
    output hspc_pkg::out_t                             m_data,
    input  wire hspc_pkg::cmd_t                        cmd_i,
    output hspc_pkg::stat_t                            stat_o
);

    localparam int CB   = COORD_BITS;
    localparam int BW   = hspc_pkg::BOX_W;
    localparam int SW   = CB + BW;
    localparam int RW   = ((CB > BW) ? CB : BW) + 1;
    localparam int QW   = 2 * CB;
    localparam int SUMW = QW + 2;
    localparam int EW   = (SUMW > hspc_pkg::THR_W) ? SUMW : hspc_pkg::THR_W;
    localparam int BA_W = (MAX_BEADS > 1) ? $clog2(MAX_BEADS) : 1;
    localparam int SA_W = (MAX_SOLVENT > 1) ? $clog2(MAX_SOLVENT) : 1;
    localparam int BT_W = $clog2(MAX_BEADS + 1);
    localparam int PC_W = $clog2(MAX_SOLVENT + 1);
    localparam int IW   = $clog2(MAX_BEADS + MAX_SOLVENT + 1);
    localparam int CW   = (PC_W > hspc_pkg::TARGET_W) ? PC_W : hspc_pkg::TARGET_W;
    localparam int PW   = 3 * CB;

    // configuration
    logic [BW-1:0]                     box_len_reg;
    logic [hspc_pkg::THR_W-1:0]        bead_thr_reg, solv_thr_reg;
    logic [hspc_pkg::TRIES_W-1:0]      max_tries_reg;
    logic [hspc_pkg::TARGET_W-1:0]     target_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_len_reg   <= '1;
            bead_thr_reg  <= '0;
            solv_thr_reg  <= '0;
            max_tries_reg <= '1;
            target_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hspc_pkg::CFG_BOX_LENGTH:   box_len_reg   <= cfg_wdata[BW-1:0];
                hspc_pkg::CFG_BEAD_THR_SQ:  bead_thr_reg  <= cfg_wdata[hspc_pkg::THR_W-1:0];
                hspc_pkg::CFG_SOLV_THR_SQ:  solv_thr_reg  <= cfg_wdata[hspc_pkg::THR_W-1:0];
                hspc_pkg::CFG_MAX_TRIES:    max_tries_reg <= cfg_wdata[hspc_pkg::TRIES_W-1:0];
                hspc_pkg::CFG_TARGET_COUNT: target_reg    <= cfg_wdata[hspc_pkg::TARGET_W-1:0];
                default: ;
            endcase
        end
    end

    // captured request
    hspc_pkg::in_t req_reg;
    logic [PW-1:0] cand_pos;

    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            req_reg <= s_data;
        end
    end

    assign cand_pos = {CB'(req_reg.coord_x), CB'(req_reg.coord_y), CB'(req_reg.coord_z)};

    // counters
    logic [BT_W-1:0]              bead_total_reg;
    logic [PC_W-1:0]              placed_reg;
    logic [hspc_pkg::TRIES_W-1:0] failed_reg;
    logic                         err_reg;
    logic [PC_W-1:0]              placed_after;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bead_total_reg <= '0;
            placed_reg     <= '0;
            failed_reg     <= '0;
            err_reg        <= 1'b0;
        end else if (cmd_i.emit) begin
            case (cmd_i.res)
                hspc_pkg::ST_BEAD_STORED:    bead_total_reg <= bead_total_reg + 1'b1;
                hspc_pkg::ST_ACCEPTED: begin
                    placed_reg <= placed_reg + 1'b1;
                    failed_reg <= '0;
                end
                hspc_pkg::ST_REJECTED:       failed_reg <= failed_reg + 1'b1;
                hspc_pkg::ST_TRIES_EXCEEDED: err_reg    <= 1'b1;
                default: ;
            endcase
        end
    end

    assign placed_after = (cmd_i.res == hspc_pkg::ST_ACCEPTED) ? placed_reg + 1'b1
                                                               : placed_reg;

    // position stores
    logic [PW-1:0] bead_mem [MAX_BEADS];
    logic [PW-1:0] sol_mem  [MAX_SOLVENT];
    logic [PW-1:0] bead_rd_reg, sol_rd_reg;

    always_ff @(posedge aclk) begin
        if (cmd_i.emit && cmd_i.res == hspc_pkg::ST_BEAD_STORED) begin
            bead_mem[bead_total_reg[BA_W-1:0]] <= cand_pos;
        end
        if (cmd_i.emit && cmd_i.res == hspc_pkg::ST_ACCEPTED) begin
            sol_mem[placed_reg[SA_W-1:0]] <= cand_pos;
        end
    end

    // scan address walk: beads first, then placed particles
    logic [IW-1:0]  idx_reg, scan_total, sol_idx;
    logic           rd_is_bead, issue_done;
    logic           rd_valid_reg;
    hspc_pkg::tag_t rd_tag_reg;

    assign scan_total = IW'(bead_total_reg) + IW'(placed_reg);
    assign issue_done = (idx_reg >= scan_total);
    assign rd_is_bead = (idx_reg < IW'(bead_total_reg));
    assign sol_idx    = idx_reg - IW'(bead_total_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd_i.scan_issue;
            if (cmd_i.scan_start) begin
                idx_reg <= '0;
            end else if (cmd_i.scan_issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.scan_issue) begin
            rd_tag_reg <= rd_is_bead ? hspc_pkg::TAG_BEAD : hspc_pkg::TAG_SOLV;
            if (rd_is_bead) begin
                bead_rd_reg <= bead_mem[idx_reg[BA_W-1:0]];
            end else begin
                sol_rd_reg <= sol_mem[sol_idx[SA_W-1:0]];
            end
        end
    end

    // pipeline input: candidate first, then stored entries
    logic           in_v;
    hspc_pkg::tag_t in_tag;
    logic [CB-1:0]  in_c [3];
    logic [PW-1:0]  in_pos;

    assign in_v   = cmd_i.scan_start | rd_valid_reg;
    assign in_tag = cmd_i.scan_start ? hspc_pkg::TAG_CAND : rd_tag_reg;
    assign in_pos = cmd_i.scan_start ? cand_pos :
                    (rd_tag_reg == hspc_pkg::TAG_BEAD) ? bead_rd_reg : sol_rd_reg;
    assign in_c[0] = in_pos[3*CB-1:2*CB];
    assign in_c[1] = in_pos[2*CB-1:CB];
    assign in_c[2] = in_pos[CB-1:0];

    // modulo reduction, one restoring step per stage (box length shifted by K)
    logic           mv_reg [CB];
    hspc_pkg::tag_t mt_reg [CB];
    logic [CB-1:0]  mr_reg [CB][3];
    logic [CB-1:0]  mv_vec;

    for (genvar j = 0; j < CB; j++) begin : g_mod
        localparam int K = CB - 1 - j;
        logic           pv;
        hspc_pkg::tag_t pt;
        logic [CB-1:0]  pc [3];
        logic [SW-1:0]  sh;

        if (j == 0) begin : g_first
            assign pv = in_v;
            assign pt = in_tag;
            assign pc = in_c;
        end else begin : g_next
            assign pv = mv_reg[j-1];
            assign pt = mt_reg[j-1];
            assign pc = mr_reg[j-1];
        end

        assign sh        = SW'(box_len_reg) << K;
        assign mv_vec[j] = mv_reg[j];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mv_reg[j] <= 1'b0;
            end else begin
                mv_reg[j] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            mt_reg[j] <= pt;
            for (int a = 0; a < 3; a++) begin
                mr_reg[j][a] <= (SW'(pc[a]) >= sh) ? pc[a] - sh[CB-1:0] : pc[a];
            end
        end
    end

    // reduced candidate
    logic [CB-1:0] cr_reg [3];

    always_ff @(posedge aclk) begin
        if (mv_reg[CB-1] && mt_reg[CB-1] == hspc_pkg::TAG_CAND) begin
            cr_reg <= mr_reg[CB-1];
        end
    end

    // gap stages, square, sum, compare
    logic           g1v_reg, g2v_reg, sqv_reg, smv_reg;
    hspc_pkg::tag_t g1t_reg, g2t_reg, sqt_reg, smt_reg;
    logic [RW-1:0]  g1_reg [3];
    logic [CB-1:0]  g2_reg [3];
    logic [QW-1:0]  sq_reg [3];
    logic [SUMW-1:0] sum_reg;
    logic           overlap_reg;
    logic           box_zero;
    logic [EW-1:0]  thr_sel;

    assign box_zero = (box_len_reg == '0);
    assign thr_sel  = (smt_reg == hspc_pkg::TAG_BEAD) ? EW'(bead_thr_reg) : EW'(solv_thr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1v_reg     <= 1'b0;
            g2v_reg     <= 1'b0;
            sqv_reg     <= 1'b0;
            smv_reg     <= 1'b0;
            overlap_reg <= 1'b0;
        end else begin
            g1v_reg <= mv_reg[CB-1];
            g2v_reg <= g1v_reg;
            sqv_reg <= g2v_reg;
            smv_reg <= sqv_reg;
            if (cmd_i.scan_start) begin
                overlap_reg <= 1'b0;
            end else if (smv_reg && smt_reg != hspc_pkg::TAG_CAND &&
                         EW'(sum_reg) < thr_sel) begin
                overlap_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        g1t_reg <= mt_reg[CB-1];
        g2t_reg <= g1t_reg;
        sqt_reg <= g2t_reg;
        smt_reg <= sqt_reg;
        for (int a = 0; a < 3; a++) begin
            // difference modulo box length, or plain distance when the box is zero
            if (box_zero) begin
                g1_reg[a] <= (cr_reg[a] >= mr_reg[CB-1][a]) ?
                             RW'(cr_reg[a]) - RW'(mr_reg[CB-1][a]) :
                             RW'(mr_reg[CB-1][a]) - RW'(cr_reg[a]);
            end else if (RW'(cr_reg[a]) + RW'(box_len_reg) - RW'(mr_reg[CB-1][a]) >=
                         RW'(box_len_reg)) begin
                g1_reg[a] <= RW'(cr_reg[a]) - RW'(mr_reg[CB-1][a]);
            end else begin
                g1_reg[a] <= RW'(cr_reg[a]) + RW'(box_len_reg) - RW'(mr_reg[CB-1][a]);
            end
            // nearest image
            if (!box_zero && ((RW + 1)'(g1_reg[a]) << 1) > (RW + 1)'(box_len_reg)) begin
                g2_reg[a] <= CB'(RW'(box_len_reg) - g1_reg[a]);
            end else begin
                g2_reg[a] <= CB'(g1_reg[a]);
            end
            sq_reg[a] <= QW'(g2_reg[a]) * QW'(g2_reg[a]);
        end
        sum_reg <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
    end

    // result register
    logic           m_valid_reg;
    hspc_pkg::out_t out_reg;
    logic           out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.emit) begin
            out_reg.status <= cmd_i.res;
            case (cmd_i.res)
                hspc_pkg::ST_BEAD_STORED: out_reg.slot_index <= hspc_pkg::SLOT_W'(bead_total_reg);
                hspc_pkg::ST_ACCEPTED:    out_reg.slot_index <= hspc_pkg::SLOT_W'(placed_reg);
                default:                  out_reg.slot_index <= '0;
            endcase
            out_reg.placed_total <= hspc_pkg::TOTAL_W'(placed_after);
            out_reg.all_placed   <= (CW'(placed_after) == CW'(target_reg));
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // status to controller
    assign stat_o.is_load     = (req_reg.opcode == hspc_pkg::OP_LOAD);
    assign stat_o.bead_full   = (bead_total_reg == BT_W'(MAX_BEADS));
    assign stat_o.err_latched = err_reg;
    assign stat_o.complete    = (CW'(placed_reg) >=
                                 ((CW'(target_reg) < CW'(MAX_SOLVENT)) ? CW'(target_reg)
                                                                       : CW'(MAX_SOLVENT)));
    assign stat_o.tries_hit   = (failed_reg >= max_tries_reg);
    assign stat_o.issue_done  = issue_done;
    assign stat_o.pipe_empty  = !rd_valid_reg && !g1v_reg && !g2v_reg && !sqv_reg &&
                                !smv_reg && (mv_vec == '0);
    assign stat_o.overlap     = overlap_reg;
    assign stat_o.out_free    = out_free;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.emit |-> out_free)
        else $error("result issued while output register busy");

    a_bead_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bead_total_reg <= BT_W'(MAX_BEADS))
        else $error("bead count beyond store size");

    a_accept_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.emit && cmd_i.res == hspc_pkg::ST_ACCEPTED) |=> failed_reg == '0)
        else $error("try counter not cleared by accepted particle");

    a_issue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.scan_issue |-> !issue_done)
        else $error("store read issued past last entry");

endmodule
`default_nettype wire

FILE: tb/hspc_checker.sv
// Result checker for the hard-sphere placement checker: watches the config port and both
// request/result channels, predicts each result and compares field by field.
// Depends on hspc_pkg.
module hspc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [hspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hspc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  hspc_pkg::in_t                   s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  hspc_pkg::out_t                  m_data,
    output int                              errors,
    output int                              pending,
    output int                              n_checked,
    output int                              n_placed,
    output int                              n_rejected
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BEAD_DEPTH = 256;
    localparam int SOLV_DEPTH = 1024;

    // shadow configuration
    logic [hspc_pkg::BOX_W-1:0]    box_len;
    logic [hspc_pkg::THR_W-1:0]    bead_thr;
    logic [hspc_pkg::THR_W-1:0]    solv_thr;
    logic [hspc_pkg::TRIES_W-1:0]  try_limit;
    logic [hspc_pkg::TARGET_W-1:0] target;

    // shadow state
    logic [59:0]                   beads [BEAD_DEPTH];
    logic [59:0]                   solvent [SOLV_DEPTH];
    int unsigned                   bead_cnt;
    int unsigned                   placed;
    logic [hspc_pkg::TRIES_W-1:0]  fail_run;
    logic                          err_flag;

    hspc_pkg::out_t                expected_q [$];
    hspc_pkg::out_t                want;

    // minimum image separation along one axis
    function automatic longint unsigned axis_sep(longint unsigned a, longint unsigned b,
                                                 longint unsigned len);
        longint unsigned r;
        if (len == 0) return (a > b) ? a - b : b - a;
        r = (a % len + len - b % len) % len;
        if (2 * r > len) r = len - r;
        return r;
    endfunction

    function automatic longint unsigned sep_sq(logic [59:0] p, logic [59:0] q,
                                               longint unsigned len);
        longint unsigned s, g;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            g = axis_sep(64'(p[k*20 +: 20]), 64'(q[k*20 +: 20]), len);
            s += g * g;
        end
        return s;
    endfunction

    task automatic place_or_store(input hspc_pkg::in_t req, output hspc_pkg::out_t res);
        logic [59:0]       p;
        longint unsigned   goal;
        logic              hit;
        hspc_pkg::status_t st;
        int unsigned       slot;
        p = {req.coord_z, req.coord_y, req.coord_x};
        goal = (target < SOLV_DEPTH) ? 64'(target) : 64'(SOLV_DEPTH);
        hit = 1'b0;
        slot = 0;
        if (req.opcode == hspc_pkg::OP_LOAD) begin
            if (bead_cnt >= BEAD_DEPTH) begin
                st = hspc_pkg::ST_BEAD_FULL;
            end else begin
                beads[bead_cnt] = p;
                slot = bead_cnt;
                bead_cnt++;
                st = hspc_pkg::ST_BEAD_STORED;
            end
        end else if (err_flag) begin
            st = hspc_pkg::ST_TRIES_EXCEEDED;
        end else if (placed >= goal) begin
            st = hspc_pkg::ST_COMPLETE;
        end else if (fail_run >= try_limit) begin
            err_flag = 1'b1;
            st = hspc_pkg::ST_TRIES_EXCEEDED;
        end else begin
            for (int j = 0; j < bead_cnt && !hit; j++)
                if (sep_sq(p, beads[j], 64'(box_len)) < bead_thr) hit = 1'b1;
            for (int j = 0; j < placed && !hit; j++)
                if (sep_sq(p, solvent[j], 64'(box_len)) < solv_thr) hit = 1'b1;
            if (hit) begin
                fail_run = fail_run + 1'b1;
                st = hspc_pkg::ST_REJECTED;
            end else begin
                solvent[placed] = p;
                slot = placed;
                placed++;
                fail_run = '0;
                st = hspc_pkg::ST_ACCEPTED;
            end
        end
        res.status       = st;
        res.slot_index   = slot[hspc_pkg::SLOT_W-1:0];
        res.placed_total = placed[hspc_pkg::TOTAL_W-1:0];
        res.all_placed   = (placed == 32'(target));
    endtask

    task automatic report(input string field, input longint unsigned got,
                          input longint unsigned exp);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, field, got, exp);
        errors++;
    endtask

    initial begin
        errors = 0;
        pending = 0;
        n_checked = 0;
        n_placed = 0;
        n_rejected = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            box_len   <= 20'hFFFFF;
            bead_thr  <= '0;
            solv_thr  <= '0;
            try_limit <= '1;
            target    <= '0;
            bead_cnt  = 0;
            placed    = 0;
            fail_run  = '0;
            err_flag  = 1'b0;
            expected_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                place_or_store(s_data, want);
                expected_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result, status", 64'(m_data.status), 64'd0);
                end else begin
                    want = expected_q.pop_front();
                    n_checked++;
                    if (want.status == hspc_pkg::ST_ACCEPTED) n_placed++;
                    if (want.status == hspc_pkg::ST_REJECTED) n_rejected++;
                    if (m_data.status != want.status)
                        report("status", 64'(m_data.status), 64'(want.status));
                    if (m_data.slot_index != want.slot_index)
                        report("slot_index", 64'(m_data.slot_index), 64'(want.slot_index));
                    if (m_data.placed_total != want.placed_total)
                        report("placed_total", 64'(m_data.placed_total),
                               64'(want.placed_total));
                    if (m_data.all_placed != want.all_placed)
                        report("all_placed", 64'(m_data.all_placed), 64'(want.all_placed));
                end
            end
            // registers only change while idle, so this ordering is safe
            if (cfg_we) begin
                case (cfg_index)
                    hspc_pkg::CFG_BOX_LENGTH:   box_len   <= cfg_wdata[hspc_pkg::BOX_W-1:0];
                    hspc_pkg::CFG_BEAD_THR_SQ:  bead_thr  <= cfg_wdata[hspc_pkg::THR_W-1:0];
                    hspc_pkg::CFG_SOLV_THR_SQ:  solv_thr  <= cfg_wdata[hspc_pkg::THR_W-1:0];
                    hspc_pkg::CFG_MAX_TRIES:    try_limit <= cfg_wdata[hspc_pkg::TRIES_W-1:0];
                    hspc_pkg::CFG_TARGET_COUNT: target    <= cfg_wdata[hspc_pkg::TARGET_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_q.size();
    end
endmodule

FILE: tb/tb_top.sv
// Testbench top for the hard-sphere placement checker: clock, reset, config writes,
// request/result stimulus with random idling and one long output stall, and the verdict.
// Depends on hspc_pkg, hard_sphere_placement_checker_top and hspc_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Worst case is far below this: ~460 requests, each scanning at most
    // 256 beads + a few hundred particles, plus gaps and one long output stall.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int STALL_AT    = 60;    // result count where the long stall starts
    localparam int STALL_LEN   = 3000;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [hspc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hspc_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    hspc_pkg::in_t                   s_data;
    logic                            m_valid;
    logic                            m_ready;
    hspc_pkg::out_t                  m_data;

    int errors, pending, n_checked, n_placed, n_rejected;
    int cycles;
    int loads_sent;          // bead loads issued, to know when the store is full
    int results_seen;
    bit no_gaps;             // stretches where both sides run flat out

    hard_sphere_placement_checker_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    hspc_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .errors     (errors),
        .pending    (pending),
        .n_checked  (n_checked),
        .n_placed   (n_placed),
        .n_rejected (n_rejected)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random hold-off before each result, and once a long stall
    // so the output register and the request side back up.
    initial begin
        int w;
        m_ready <= 1'b0;
        results_seen = 0;
        @(posedge aclk);
        forever begin
            w = no_gaps ? 0 : $urandom_range(0, 3);
            if (results_seen == STALL_AT) w = STALL_LEN;
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            results_seen++;
        end
    end

    // one request; valid is left high so back-to-back requests never drop it
    task automatic send_request(input logic op, input logic [19:0] x, y, z);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= '{opcode: op, coord_x: x, coord_y: y, coord_z: z};
        s_valid <= 1'b1;
        if (op == hspc_pkg::OP_LOAD) loads_sent++;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // drop valid and wait until every expected result is back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    // cfg_we is lowered by the caller once the batch of writes is done
    task automatic write_reg(input logic [hspc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hspc_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    task automatic write_all(input logic [19:0] box, input logic [39:0] bthr, sthr,
                             input logic [31:0] tries, input logic [10:0] tgt);
        write_reg(hspc_pkg::CFG_BOX_LENGTH, hspc_pkg::CFG_DATA_W'(box));
        write_reg(hspc_pkg::CFG_BEAD_THR_SQ, bthr);
        write_reg(hspc_pkg::CFG_SOLV_THR_SQ, sthr);
        write_reg(hspc_pkg::CFG_MAX_TRIES, hspc_pkg::CFG_DATA_W'(tries));
        write_reg(hspc_pkg::CFG_TARGET_COUNT, hspc_pkg::CFG_DATA_W'(tgt));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [19:0] pick_coord(input logic [19:0] box);
        if (box == 0 || $urandom_range(0, 4) == 0) return 20'($urandom);
        return 20'($urandom_range(0, box - 1));
    endfunction

    initial begin
        logic [19:0] box;
        logic [39:0] sep, bthr, sthr;
        logic [31:0] tries;
        logic [10:0] tgt;
        int n;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        loads_sent = 0;
        no_gaps    = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed ---
        // reset target is zero: a candidate is already complete
        send_request(hspc_pkg::OP_PROPOSE, 20'd1, 20'd2, 20'd3);
        send_request(hspc_pkg::OP_LOAD, 20'd0, 20'd0, 20'd0);
        send_request(hspc_pkg::OP_LOAD, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);   // at box edge, wraps
        settle();

        write_all(20'd1000, 40'd10000, 40'd2500, 32'd100, 11'd1024);
        send_request(hspc_pkg::OP_PROPOSE, 20'd999, 20'd0, 20'd0);      // overlaps bead through wrap
        send_request(hspc_pkg::OP_PROPOSE, 20'd300, 20'd300, 20'd300);
        send_request(hspc_pkg::OP_PROPOSE, 20'd300, 20'd300, 20'd350);  // exactly at threshold
        send_request(hspc_pkg::OP_PROPOSE, 20'd300, 20'd300, 20'd251);  // just inside
        send_request(hspc_pkg::OP_PROPOSE, 20'd1800, 20'd1800, 20'd1050); // outside the box
        send_request(hspc_pkg::OP_PROPOSE, 20'd800, 20'd800, 20'd800);    // half-box tie
        send_request(hspc_pkg::OP_LOAD, 20'd700, 20'd100, 20'd900);       // bead during placement
        send_request(hspc_pkg::OP_PROPOSE, 20'd700, 20'd100, 20'd950);
        settle();

        // no wrapping at zero box length
        write_reg(hspc_pkg::CFG_BOX_LENGTH, 40'd0);
        cfg_we <= 1'b0;
        @(posedge aclk);
        send_request(hspc_pkg::OP_PROPOSE, 20'hFFFFF, 20'd0, 20'd0);
        send_request(hspc_pkg::OP_PROPOSE, 20'd0, 20'hFFFFF, 20'hFFFFF);
        send_request(hspc_pkg::OP_PROPOSE, 20'hFFFF0, 20'd10, 20'd10);
        settle();

        // unit box, zero thresholds: everything fits
        write_all(20'd1, 40'd0, 40'd0, 32'hFFFFFFFF, 11'd1024);
        send_request(hspc_pkg::OP_PROPOSE, 20'd7, 20'd7, 20'd7);
        send_request(hspc_pkg::OP_PROPOSE, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        settle();
        // largest thresholds: everything collides
        write_all(20'hFFFFF, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 32'd50, 11'd1024);
        send_request(hspc_pkg::OP_PROPOSE, 20'h55555, 20'hAAAAA, 20'd0);
        send_request(hspc_pkg::OP_PROPOSE, 20'hAAAAA, 20'h55555, 20'hFFFFF);
        settle();

        // --- random phases with varied geometry ---
        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 4))
                0: box = 20'($urandom_range(2, 64));
                1: box = 20'($urandom_range(65, 5000));
                2: box = 20'($urandom_range(1, 20'hFFFFF));
                3: box = 20'hFFFFF;
                default: box = (ph == 2) ? 20'd0 : 20'($urandom_range(100, 3000));
            endcase
            sep  = 40'(((box == 0) ? 20'd3000 : box) / $urandom_range(4, 30));
            bthr = sep * sep;
            sep  = 40'(((box == 0) ? 20'd3000 : box) / $urandom_range(6, 40));
            sthr = sep * sep;
            tries = (ph == 0) ? 32'hFFFFFFFF : $urandom_range(20, 2000);
            if (ph == 1) tgt = 11'd0;
            else if ($urandom_range(0, 3) == 0) tgt = 11'($urandom_range(0, 40));
            else tgt = 11'($urandom_range(0, 1024));
            no_gaps = (ph == 3);
            write_all(box, bthr, sthr, tries, tgt);
            n = $urandom_range(30, 40);
            for (int i = 0; i < n; i++)
                send_request(($urandom_range(0, 9) == 0) ? hspc_pkg::OP_LOAD
                                                         : hspc_pkg::OP_PROPOSE,
                             pick_coord(box), pick_coord(box), pick_coord(box));
            settle();
        end
        no_gaps = 1'b0;

        // --- fill the bead store, overflow it, then test against a full store ---
        write_all(20'd4000, 40'd2500, 40'd900, 32'd500, 11'd1024);
        while (loads_sent < 259)
            send_request(hspc_pkg::OP_LOAD, pick_coord(20'd4000), pick_coord(20'd4000),
                         pick_coord(20'd4000));
        for (int i = 0; i < 8; i++)
            send_request(hspc_pkg::OP_PROPOSE, pick_coord(20'd4000), pick_coord(20'd4000),
                         pick_coord(20'd4000));
        settle();

        // --- try limit of zero: the next candidate latches the error for good ---
        write_all(20'd4000, 40'd2500, 40'd900, 32'd0, 11'd1024);
        for (int i = 0; i < 4; i++)
            send_request(hspc_pkg::OP_PROPOSE, pick_coord(20'd4000), pick_coord(20'd4000),
                         pick_coord(20'd4000));
        send_request(hspc_pkg::OP_LOAD, 20'd1, 20'd1, 20'd1);
        settle();

        $display("Checked %0d results (%0d placed, %0d rejected) over %0d bead loads,",
                 n_checked, n_placed, n_rejected, loads_sent);
        $display("box sizes from zero to full range, store overflow and latched try limit.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

FILE: filelist.f
src/hspc_pkg.sv
src/hspc_ctrl.sv
src/hspc_dpath.sv
src/hard_sphere_placement_checker_top.sv
tb/hspc_checker.sv
tb/tb_top.sv
